// ===== rtl/tile_fade_shrink_transform_top_defines.svh =====
// Assertion macros shared by the tile fade/shrink RTL.
// Uses the clk and rst names of the module that includes it.
`ifndef TILE_FADE_SHRINK_TRANSFORM_TOP_DEFINES_SVH
`define TILE_FADE_SHRINK_TRANSFORM_TOP_DEFINES_SVH

// checked outside reset
`define TFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tfs_pkg.sv =====
// Shared types and constants for the tile fade/shrink transform.
// No dependencies.
`default_nettype none
package tfs_pkg;
  localparam int COORD_W = 24;
  localparam int NUM_W = 27;
  localparam int REM_W = 28;
  localparam int Q_W = 16;
  localparam int IN_W = 208;
  localparam int OUT_W = 192;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [8:0] MAX_DIM = 9'd256;

  localparam logic [1:0] CLS_OFF = 2'd0;
  localparam logic [1:0] CLS_SHRINK = 2'd1;
  localparam logic [1:0] CLS_ORIG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_H = 3'd5;

  typedef logic [7:0][COORD_W-1:0] corners_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] cols;
    logic [8:0] rows;
    logic [16:0] progress;
    logic [23:0] step_w;
    logic [23:0] step_h;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    corners_t crd;
  } item_t;
endpackage
`default_nettype wire

// ===== rtl/tfs_front.sv =====
// Front end: configuration registers and tile classification.
// Forms the fade ratio numerator/denominator; depends on tfs_pkg.
`default_nettype none
module tfs_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // tile_col, tile_row, bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y
  input  wire logic [tfs_pkg::IN_W-1:0] s_tdata,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output tfs_pkg::cfg_t cfg,
  output logic q_valid,
  input  wire logic q_ready,
  output tfs_pkg::item_t q_item
);
  import tfs_pkg::*;

  logic [7:0] col, row;
  logic [8:0] cols_c, rows_c, sum_t;
  logic [9:0] sum_cr, mul_a;
  logic [16:0] p_c, q_c, mul_b;
  logic [NUM_W-1:0] prod, shifted, num, den;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode: 2'd0, cols: 9'd1, rows: 9'd1, progress: 17'd0,
               step_w: 24'd0, step_h: 24'd0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     cfg.mode <= cfg_data[1:0];
        REG_COLS:     cfg.cols <= cfg_data[8:0];
        REG_ROWS:     cfg.rows <= cfg_data[8:0];
        REG_PROGRESS: cfg.progress <= cfg_data[16:0];
        REG_STEP_W:   cfg.step_w <= cfg_data;
        REG_STEP_H:   cfg.step_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    col = s_tdata[7:0];
    row = s_tdata[15:8];
    cols_c = (cfg.cols > MAX_DIM) ? MAX_DIM : cfg.cols;
    rows_c = (cfg.rows > MAX_DIM) ? MAX_DIM : cfg.rows;
    p_c = (cfg.progress > ONE_Q16) ? ONE_Q16 : cfg.progress;
    q_c = ONE_Q16 - p_c;
    sum_cr = {1'b0, cols_c} + {1'b0, rows_c};
    sum_t = {1'b0, col} + {1'b0, row};
    // mode bit 1: rows only; mode bit 0: remaining progress, roles swapped
    mul_a = cfg.mode[1] ? {1'b0, rows_c} : sum_cr;
    mul_b = cfg.mode[0] ? q_c : p_c;
    prod = NUM_W'(mul_a) * NUM_W'(mul_b);
    shifted = cfg.mode[1] ? {3'b0, row, 16'b0} : {2'b0, sum_t, 16'b0};
    num = cfg.mode[0] ? prod : shifted;
    den = cfg.mode[0] ? shifted : prod;
    q_item.num = num;
    q_item.den = den;
    q_item.crd = corners_t'(s_tdata[IN_W-1:16]);
    if (den == '0) q_item.cls = CLS_ORIG;
    else if (num == '0) q_item.cls = CLS_OFF;
    else if (num >= den) q_item.cls = CLS_ORIG;
    else q_item.cls = CLS_SHRINK;
  end

  assign q_valid = s_tvalid;
  assign s_tready = q_ready;
endmodule
`default_nettype wire

// ===== rtl/tfs_queue.sv =====
// Short FIFO between the classifier and the arithmetic pipeline.
// Depends on tfs_pkg and the assertion macro header.
`default_nettype none
`include "tile_fade_shrink_transform_top_defines.svh"
module tfs_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire tfs_pkg::item_t in_item,
  output logic out_valid,
  input  wire logic out_ready,
  output tfs_pkg::item_t out_item
);
  import tfs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0] count;
  logic push, pop;

  assign in_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  `TFS_ASSERT(a_count_bound, (count <= (PTR_W+1)'(QUEUE_DEPTH)), "queue count overflow")
  `TFS_ASSERT(a_count_track, (push && !pop |=> count == $past(count) + 1'b1), "count missed push")
  `TFS_ASSERT(a_ptr_gap, (count == '0 || count == (PTR_W+1)'(QUEUE_DEPTH) || wr_ptr != rd_ptr), "pointers disagree with count")
endmodule
`default_nettype wire

// ===== rtl/tfs_back.sv =====
// Back end: restoring divider, power chain, step multiply, corner update.
// Depends on tfs_pkg and the assertion macro header.
`default_nettype none
`include "tile_fade_shrink_transform_top_defines.svh"
module tfs_back #(
  parameter int POWER_EXPONENT = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tfs_pkg::cfg_t cfg,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire tfs_pkg::item_t q_item,
  output logic m_tvalid,
  input  wire logic m_tready,
  // out_bl_x, out_bl_y, out_br_x, out_br_y, out_tl_x, out_tl_y, out_tr_x, out_tr_y
  output logic [tfs_pkg::OUT_W-1:0] m_tdata,
  // tile_state
  output logic [1:0] m_tuser
);
  import tfs_pkg::*;

  localparam int POW_N = POWER_EXPONENT - 1;
  localparam logic [7:0] ADD_MASK = 8'b10110001;  // corners that move by +delta
  localparam logic signed [25:0] SAT_HI = 26'sd8388607;
  localparam logic signed [25:0] SAT_LO = -26'sd8388608;

  typedef struct packed {
    logic [1:0] cls;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] den;
    logic [Q_W-1:0] quo;
    corners_t crd;
  } div_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [Q_W-1:0] r;
    logic [Q_W-1:0] f;
    corners_t crd;
  } pow_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    corners_t crd;
  } mul_t;

  function automatic div_t div_step(input div_t d);
    div_t o;
    logic [REM_W-1:0] rem2;
    logic ge;
    o = d;
    rem2 = {d.rem[REM_W-2:0], 1'b0};
    ge = rem2 >= {1'b0, d.den};
    o.rem = ge ? rem2 - {1'b0, d.den} : rem2;
    o.quo = {d.quo[Q_W-2:0], ge};
    return o;
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic signed [25:0] v);
    logic signed [25:0] t;
    t = v;
    if (v > SAT_HI) t = SAT_HI;
    if (v < SAT_LO) t = SAT_LO;
    return t[COORD_W-1:0];
  endfunction

  logic en;
  logic div_v [Q_W+1];
  div_t div_d [Q_W+1];
  logic pow_v [POW_N+1];
  pow_t pow_d [POW_N+1];
  logic mul_v;
  mul_t mul_d;
  logic [16:0] keep;
  logic [40:0] px, py;
  corners_t shrunk;

  assign en = !m_tvalid || m_tready;
  assign q_ready = en;

  assign div_v[0] = q_valid;
  assign div_d[0] = '{cls: q_item.cls, rem: {1'b0, q_item.num}, den: q_item.den,
                      quo: '0, crd: q_item.crd};

  // one quotient bit per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) div_v[k] <= 1'b0;
      else if (en) div_v[k] <= div_v[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) div_d[k] <= div_step(div_d[k-1]);
    end
  end

  assign pow_v[0] = div_v[Q_W];
  assign pow_d[0] = '{cls: div_d[Q_W].cls, r: div_d[Q_W].quo, f: div_d[Q_W].quo,
                      crd: div_d[Q_W].crd};

  // f = (f*r)>>16, one product per stage
  for (genvar j = 1; j <= POW_N; j++) begin : g_pow
    logic [2*Q_W-1:0] pp;
    assign pp = pow_d[j-1].f * pow_d[j-1].r;
    always_ff @(posedge clk) begin
      if (rst) pow_v[j] <= 1'b0;
      else if (en) pow_v[j] <= pow_v[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) pow_d[j] <= '{cls: pow_d[j-1].cls, r: pow_d[j-1].r,
                            f: pp[2*Q_W-1:Q_W], crd: pow_d[j-1].crd};
    end
  end

  assign keep = ONE_Q16 - {1'b0, pow_d[POW_N].f};
  assign px = 41'(cfg.step_w) * 41'(keep);
  assign py = 41'(cfg.step_h) * 41'(keep);

  always_ff @(posedge clk) begin
    if (rst) mul_v <= 1'b0;
    else if (en) mul_v <= pow_v[POW_N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mul_d.cls <= pow_d[POW_N].cls;
      mul_d.dx <= cfg.mode[1] ? '0 : px[40:17];
      mul_d.dy <= py[40:17];
      mul_d.crd <= pow_d[POW_N].crd;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic signed [25:0] base, delta;
      base = 26'(signed'(mul_d.crd[i]));
      delta = (i % 2 == 0) ? signed'({2'b0, mul_d.dx}) : signed'({2'b0, mul_d.dy});
      shrunk[i] = ADD_MASK[i] ? sat(base + delta) : sat(base - delta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= mul_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= mul_d.cls;
      case (mul_d.cls)
        CLS_OFF:    m_tdata <= '0;
        CLS_SHRINK: m_tdata <= shrunk;
        default:    m_tdata <= mul_d.crd;
      endcase
    end
  end

  `TFS_ASSERT_ALWAYS(a_reset_clears, ($past(rst) |-> !m_tvalid), "output valid after reset")
  `TFS_ASSERT(a_off_zero, (m_tvalid && m_tuser == CLS_OFF |-> m_tdata == '0), "off tile has corners")
  `TFS_ASSERT(a_stall_holds, (!en && mul_v |=> $stable(mul_d) && mul_v), "pipeline moved while stalled")
endmodule
`default_nettype wire

// ===== rtl/tile_fade_shrink_transform_top.sv =====
// Tile fade/shrink transform: one tile in, one tile out, one tile per cycle sustained
// while the output is not stalled. Path from the accepting edge to the output register:
// one queue write, a 16-stage restoring divider forms the fade ratio, POWER_EXPONENT-1
// multiply stages raise it to the power, one stage scales the half steps, one registers
// the corners. A 4-entry queue sits between classification and the pipeline; output
// stalls hold the pipeline while the queue keeps taking tiles until it is full. Config
// writes are accepted every cycle but must be made only while no tile is in flight.
// Depends on tfs_pkg, tfs_front, tfs_queue, tfs_back.
`default_nettype none
module tile_fade_shrink_transform_top #(
  parameter int POWER_EXPONENT = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // tile_col, tile_row, bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y
  input  wire logic [tfs_pkg::IN_W-1:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // out_bl_x, out_bl_y, out_br_x, out_br_y, out_tl_x, out_tl_y, out_tr_x, out_tr_y
  output logic [tfs_pkg::OUT_W-1:0] m_tdata,
  // tile_state
  output logic [1:0] m_tuser,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tfs_pkg::*;

  cfg_t cfg;
  item_t f_item, b_item;
  logic f_valid, f_ready, b_valid, b_ready;

  tfs_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  tfs_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  tfs_back #(.POWER_EXPONENT(POWER_EXPONENT)) u_back (
    .clk, .rst, .cfg,
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );
endmodule
`default_nettype wire
